@@ rtl/smsrng_pkg.sv @@
package smsrng_pkg;

    localparam int SEED_W  = 32;
    localparam int VALUE_W = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = SEED_W + MULT_W;
    localparam int TDATA_W = 64;

    localparam logic [MULT_W-1:0]  LCG_MULT  = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] OUT_CLAMP = 31'd2147483389;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_SLOT,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_w;
        logic mul;
        logic fold;
        logic init_write;
        logic set_last;
        logic update_gen;
        logic calc_slot;
        logic rd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic start_init;
        logic out_busy;
    } status_t;

endpackage

@@ rtl/smsrng_ctrl.sv @@
module smsrng_ctrl
    import smsrng_pkg::*;
#(
    parameter int TABLE_SIZE   = 32,
    parameter int WARMUP_STEPS = 8,
    parameter int CNT_W        = $clog2(TABLE_SIZE + WARMUP_STEPS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  status_t          status,
    output cmd_t             cmd,
    output logic [CNT_W-1:0] init_idx
);

    localparam logic [CNT_W-1:0] INIT_LAST = CNT_W'(TABLE_SIZE + WARMUP_STEPS - 1);
    localparam logic [CNT_W-1:0] TBL_END   = CNT_W'(TABLE_SIZE);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             init_mode_reg, init_mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            init_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_mode_reg <= init_mode_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        init_mode_next = init_mode_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_w     = 1'b1;
                    init_mode_next = status.start_init;
                    cnt_next       = INIT_LAST;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (init_mode_reg) begin
                    // warm-up steps run above the table range and are dropped
                    cmd.init_write = (cnt_reg < TBL_END);
                    if (cnt_reg == '0) begin
                        cmd.set_last   = 1'b1;
                        init_mode_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    state_next = ST_MUL;
                end else begin
                    cmd.update_gen = 1'b1;
                    state_next     = ST_SLOT;
                end
            end
            ST_SLOT: begin
                cmd.calc_slot = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign init_idx = cnt_reg;

endmodule

@@ rtl/smsrng_dp.sv @@
module smsrng_dp
    import smsrng_pkg::*;
#(
    parameter int TABLE_SIZE = 32,
    parameter int CNT_W      = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [SEED_W-1:0]  seed,
    input  logic               load_seed,
    input  cmd_t               cmd,
    input  logic [CNT_W-1:0]   init_idx,
    output status_t            status,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [VALUE_W-1:0] value,
    output logic [VALUE_W-1:0] next_seed
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int R_W   = $clog2(TABLE_SIZE + 1);
    localparam longint unsigned SLOT_DIV = 1 + 64'd2147483646 / TABLE_SIZE;
    localparam longint unsigned RECIP    = 64'd2147483648 / SLOT_DIV;
    localparam logic [VALUE_W-1:0] DIV_C  = VALUE_W'(SLOT_DIV);
    localparam logic [R_W-1:0]     RCP_C  = R_W'(RECIP);
    localparam logic [R_W:0]       TOP_IX = (R_W + 1)'(TABLE_SIZE - 1);

    logic [SEED_W-1:0]  w_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] gen_reg;
    logic [VALUE_W-1:0] last_reg;
    logic [R_W-1:0]     qe_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [VALUE_W-1:0] rd_reg;
    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] next_seed_reg;

    logic [VALUE_W-1:0] mem [TABLE_SIZE];

    logic               seed_neg;
    logic               seed_zero;
    logic [SEED_W-1:0]  w_load;
    logic [SEED_W-1:0]  w_start;
    logic [SEED_W-1:0]  fold_sum;
    logic [VALUE_W-1:0] fold_red;
    logic [VALUE_W+R_W-1:0] qe_prod;
    logic [VALUE_W+R_W-1:0] q_back;
    logic [VALUE_W+R_W-1:0] rem;
    logic [R_W:0]       q_fix;
    logic [IDX_W-1:0]   slot_next;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;

    // starting point of the generator for an accepted request
    always_comb begin
        seed_neg  = seed[SEED_W-1];
        seed_zero = (seed == '0);
        if (seed_neg) begin
            w_load = '0 - seed;
        end else if (seed_zero || (last_reg == '0)) begin
            // initialization restarts a non-negative seed from 1
            w_load = SEED_W'(1);
        end else begin
            w_load = seed;
        end
        if (load_seed) begin
            w_start           = w_load;
            status.start_init = seed_neg || seed_zero || (last_reg == '0);
        end else begin
            w_start           = (gen_reg == '0) ? SEED_W'(1) : {1'b0, gen_reg};
            status.start_init = (gen_reg == '0) || (last_reg == '0);
        end
        status.out_busy = m_tvalid_reg && !m_tready;
    end

    // fold the product modulo 2^31-1: high part plus low part, one subtract
    always_comb begin
        fold_sum = SEED_W'(prod_reg[PROD_W-1:VALUE_W]) + {1'b0, prod_reg[VALUE_W-1:0]};
        if (fold_sum >= {1'b0, LCG_MOD}) begin
            fold_red = VALUE_W'(fold_sum - {1'b0, LCG_MOD});
        end else begin
            fold_red = fold_sum[VALUE_W-1:0];
        end
    end

    // slot = last / SLOT_DIV by reciprocal estimate plus one correction, clamped to the top index
    always_comb begin
        qe_prod = last_reg * RCP_C;
        q_back  = qe_reg * DIV_C;
        rem     = {{R_W{1'b0}}, last_reg} - q_back;
        q_fix   = {1'b0, qe_reg} + ((rem >= {{R_W{1'b0}}, DIV_C}) ? (R_W + 1)'(1) : '0);
        if (q_fix > TOP_IX) begin
            q_fix = TOP_IX;
        end
        slot_next = q_fix[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_w) begin
            w_reg <= w_start;
        end else if (cmd.fold) begin
            w_reg <= {1'b0, fold_red};
        end
        if (cmd.mul) begin
            prod_reg <= w_reg * LCG_MULT;
            qe_reg   <= qe_prod[VALUE_W+R_W-1:VALUE_W];
        end
        if (cmd.calc_slot) begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg  <= '0;
            last_reg <= '0;
        end else begin
            if (cmd.fold && cmd.update_gen) begin
                gen_reg <= fold_red;
            end
            if (cmd.fold && cmd.set_last) begin
                last_reg <= fold_red;
            end else if (cmd.emit) begin
                last_reg <= rd_reg;
            end
        end
    end

    always_comb begin
        mem_we    = (cmd.fold && cmd.init_write) || cmd.emit;
        mem_waddr = cmd.emit ? slot_reg : init_idx[IDX_W-1:0];
        mem_wdata = cmd.emit ? gen_reg : fold_red;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd) begin
            rd_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            value_reg     <= (rd_reg > OUT_CLAMP) ? OUT_CLAMP : rd_reg;
            next_seed_reg <= gen_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign value     = value_reg;
    assign next_seed = next_seed_reg;

endmodule

@@ rtl/shuffled_minimal_standard_rng.sv @@
// Shuffled minimal-standard uniform generator (Lehmer x16807 mod 2^31-1
// feeding a Bays-Durham shuffle table).
// Input stream: one transfer per request. s_tuser is the load flag; when set,
// s_tdata replaces the seed. A seed of zero or less, a zero state, or a zero
// last deviate reinitializes the shuffle table first.
// Output stream: one transfer per request with the deviate and the new state.
// A generator step is a multiply, then a mod fold.
// After acceptance, a plain request runs a step, the slot divide, the table
// read and write back, which loads the output register.
// A request that reinitializes first runs WARMUP_STEPS warm-up steps,
// then TABLE_SIZE table-loading steps, before its plain request work.
// The block works on one request at a time; s_tready is high only while idle.
// Reset clears the state and last deviate, so the first request always
// initializes; the table needs no clearing since initialization fills it.
// A stalled receiver holds the output register; the block then waits at
// write back and does not take new requests until the result is taken.
module shuffled_minimal_standard_rng
    import smsrng_pkg::*;
#(
    parameter int TABLE_SIZE   = 32,
    parameter int WARMUP_STEPS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SEED_W-1:0]  s_tdata,   // [31:0] seed
    input  logic               s_tuser,   // [0] load_seed
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [30:0] value, [61:31] next_seed
);

    localparam int CNT_W = $clog2(TABLE_SIZE + WARMUP_STEPS + 1);

    cmd_t               cmd;
    status_t            status;
    logic [CNT_W-1:0]   init_idx;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] next_seed;

    smsrng_ctrl #(
        .TABLE_SIZE   (TABLE_SIZE),
        .WARMUP_STEPS (WARMUP_STEPS),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .init_idx (init_idx)
    );

    smsrng_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .CNT_W      (CNT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed      (s_tdata),
        .load_seed (s_tuser),
        .cmd       (cmd),
        .init_idx  (init_idx),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .value     (value),
        .next_seed (next_seed)
    );

    assign m_tdata = {{(TDATA_W - 2 * VALUE_W){1'b0}}, next_seed, value};

endmodule

@@ rtl/smsrng_checker.sv @@
module smsrng_checker
    import smsrng_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [SEED_W-1:0]  s_tdata,
    input logic               s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // no result is shown right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // deviate saturated, state below the modulus, padding clear
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:0] <= OUT_CLAMP) && (m_tdata[61:31] != LCG_MOD)
                     && (m_tdata[63:62] == 2'b00))
        else $error("result field out of range");

endmodule

bind shuffled_minimal_standard_rng smsrng_checker u_checker (.*);
